/* sv/kmc_pkg.sv */
// kmc_pkg: shared constants, types and state codes for the k-means block
// no dependencies
package kmc_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 8;

  localparam int COORD_W = 40;
  localparam int HALF_W  = COORD_W / 2;
  localparam int PROD_W  = 2 * HALF_W;
  localparam int DIST_W  = 2 * COORD_W + 1;
  localparam int IDX_W   = 3;
  localparam int K_W     = 4;
  localparam int ITER_W  = 8;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int PTR_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SUM_W   = COORD_W + ((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1);
  localparam int NCELL   = (MAX_CLUSTERS < 8) ? MAX_CLUSTERS : 8;
  localparam int CELL_LAT = 4;
  localparam int DRAIN_LEN = CELL_LAT * NCELL + 3;
  localparam int DRAIN_W = $clog2(DRAIN_LEN + 1);
  localparam int DSTEP_W = $clog2(SUM_W + 1);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [ITER_W-1:0] DEFAULT_ITERATIONS = ITER_W'(15);
  localparam logic [K_W-1:0]    DEFAULT_CLUSTERS   = K_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLUSTER_COUNT   = 1'b0,
    REG_ITERATION_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CLEAR,
    S_STREAM,
    S_DRAIN,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               has;
    logic [DIST_W-1:0]  best_d;
    logic [IDX_W-1:0]   idx;
  } link_t;

  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } acc_t;

  typedef struct packed {
    logic [K_W-1:0]     k;
    logic               clr;
    logic               wr_x;
    logic               wr_y;
    logic [IDX_W-1:0]   wr_idx;
    logic [COORD_W-1:0] wr_x_val;
    logic [COORD_W-1:0] wr_y_val;
  } cell_ctrl_t;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [SUM_W-1:0]   sx;
    logic [SUM_W-1:0]   sy;
    logic [CNT_W-1:0]   cnt;
  } cell_stat_t;

endpackage

/* sv/kmc_if.sv */
// kmc_in_if, kmc_out_if: valid/ready channels for points and results
// depends on kmc_pkg
interface kmc_in_if import kmc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [IDX_W-1:0]   centroid_slot;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic               last;
  modport source (output valid, kind, centroid_slot, coord_x, coord_y, last, input ready);
  modport sink (input valid, kind, centroid_slot, coord_x, coord_y, last, output ready);
endinterface

interface kmc_out_if import kmc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   cluster_index;
  logic [COORD_W-1:0] center_x;
  logic [COORD_W-1:0] center_y;
  logic [CNT_W-1:0]   member_count;
  logic               overflowed;
  logic               final_res;
  modport source (output valid, cluster_index, center_x, center_y, member_count,
                  overflowed, final_res, input ready);
  modport sink (input valid, cluster_index, center_x, center_y, member_count,
                overflowed, final_res, output ready);
endinterface

/* sv/kmc_cell.sv */
// kmc_cell: one centroid cell, distance pipeline, compare and accumulators
// depends on kmc_pkg
module kmc_cell import kmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_id,
  input  cell_ctrl_t       ctrl,
  input  link_t            li,
  output link_t            lo,
  input  acc_t             acc,
  output cell_stat_t       stat
);

  logic [COORD_W-1:0] cx, cy;
  logic [SUM_W-1:0]   sx, sy;
  logic [CNT_W-1:0]   cnt;

  link_t a_l, b_l, c_l, d_l;
  logic [COORD_W-1:0] a_dx, a_dy;
  logic [PROD_W-1:0]  b_xhh, b_xhl, b_xll, b_yhh, b_yhl, b_yll;
  logic [DIST_W-1:0]  c_dist;
  logic               active;
  logic               take;

  assign active = {1'b0, cell_id} < ctrl.k;
  assign take   = active && (!c_l.has || c_dist < c_l.best_d);

  // absolute difference, partial squares, distance, compare
  always_ff @(posedge clk) begin
    a_l.px     <= li.px;
    a_l.py     <= li.py;
    a_l.has    <= li.has;
    a_l.best_d <= li.best_d;
    a_l.idx    <= li.idx;
    a_dx       <= (li.px >= cx) ? li.px - cx : cx - li.px;
    a_dy       <= (li.py >= cy) ? li.py - cy : cy - li.py;

    b_l.px     <= a_l.px;
    b_l.py     <= a_l.py;
    b_l.has    <= a_l.has;
    b_l.best_d <= a_l.best_d;
    b_l.idx    <= a_l.idx;
    b_xhh      <= a_dx[COORD_W-1:HALF_W] * a_dx[COORD_W-1:HALF_W];
    b_xhl      <= a_dx[COORD_W-1:HALF_W] * a_dx[HALF_W-1:0];
    b_xll      <= a_dx[HALF_W-1:0] * a_dx[HALF_W-1:0];
    b_yhh      <= a_dy[COORD_W-1:HALF_W] * a_dy[COORD_W-1:HALF_W];
    b_yhl      <= a_dy[COORD_W-1:HALF_W] * a_dy[HALF_W-1:0];
    b_yll      <= a_dy[HALF_W-1:0] * a_dy[HALF_W-1:0];

    c_l.px     <= b_l.px;
    c_l.py     <= b_l.py;
    c_l.has    <= b_l.has;
    c_l.best_d <= b_l.best_d;
    c_l.idx    <= b_l.idx;
    c_dist     <= (DIST_W'(b_xhh) << (2 * HALF_W)) + (DIST_W'(b_xhl) << (HALF_W + 1))
                + DIST_W'(b_xll)
                + (DIST_W'(b_yhh) << (2 * HALF_W)) + (DIST_W'(b_yhl) << (HALF_W + 1))
                + DIST_W'(b_yll);

    d_l.px     <= c_l.px;
    d_l.py     <= c_l.py;
    d_l.has    <= c_l.has || active;
    d_l.best_d <= take ? c_dist : c_l.best_d;
    d_l.idx    <= take ? cell_id : c_l.idx;

    // valid bits
    if (rst) begin
      a_l.valid <= 1'b0;
      b_l.valid <= 1'b0;
      c_l.valid <= 1'b0;
      d_l.valid <= 1'b0;
    end else begin
      a_l.valid <= li.valid;
      b_l.valid <= a_l.valid;
      c_l.valid <= b_l.valid;
      d_l.valid <= c_l.valid;
    end
  end

  assign lo = d_l;

  // centroid and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      cx  <= '0;
      cy  <= '0;
      sx  <= '0;
      sy  <= '0;
      cnt <= '0;
    end else begin
      if (ctrl.wr_x && ctrl.wr_idx == cell_id) cx <= ctrl.wr_x_val;
      if (ctrl.wr_y && ctrl.wr_idx == cell_id) cy <= ctrl.wr_y_val;
      if (ctrl.clr) begin
        sx  <= '0;
        sy  <= '0;
        cnt <= '0;
      end else if (acc.valid && acc.idx == cell_id) begin
        sx  <= sx + SUM_W'(acc.px);
        sy  <= sy + SUM_W'(acc.py);
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  assign stat.cx  = cx;
  assign stat.cy  = cy;
  assign stat.sx  = sx;
  assign stat.sy  = sy;
  assign stat.cnt = cnt;

endmodule

/* sv/kmc_div.sv */
// kmc_div: restoring divider, one quotient bit per cycle, for centroid means
// depends on kmc_pkg
module kmc_div import kmc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               done,
  output logic [COORD_W-1:0] quotient
);

  logic               busy;
  logic [DSTEP_W-1:0] steps;
  logic [SUM_W-1:0]   q;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   dvs;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               fits;

  assign trial = {rem, q[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && steps == DSTEP_W'(1);
      if (start && !busy) begin
        busy  <= 1'b1;
        steps <= DSTEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - DSTEP_W'(1);
        if (steps == DSTEP_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      q   <= {q[SUM_W-2:0], fits};
    end
  end

  assign quotient = q[COORD_W-1:0];

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_steps_live: assert property (@(posedge clk) disable iff (rst) busy |-> steps != '0)
    else $error("divider busy with no steps left");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a division");

endmodule

/* sv/kmeans_cluster_2d.sv */
// kmeans_cluster_2d: top level, point memory, run sequencer, cell chain, divider
// depends on kmc_pkg, kmc_if, kmc_cell, kmc_div
//
// channel   dir  payload                                         transfer
// sample    in   kind, centroid_slot, coord_x, coord_y, last     valid && ready
// result    out  cluster_index, center_x, center_y,
//                member_count, overflowed, final_res             valid && ready
// cfg       in   cfg_we, cfg_idx, cfg_data                       cfg_we
//
// loading: one item per cycle; a point is written to point memory while capacity lasts, a centroid to its cell
// run: per pass, a clear state, then the points are streamed through the cell chain, then the
//   divider forms the x and y means of each non-empty cluster; empty clusters are skipped
// results: k transfers after the run; no item is taken from last until the final one
// reset: synchronous, centroids and counts cleared, no clearing pass
module kmeans_cluster_2d import kmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  kmc_in_if.sink                sample,
  kmc_out_if.source             result
);

  logic [K_W-1:0]    cluster_count;
  logic [ITER_W-1:0] iteration_count;

  state_t state, state_next;

  logic [CNT_W-1:0]   loaded;
  logic               drop;
  logic [K_W-1:0]     k;
  logic [ITER_W-1:0]  iters_left;
  logic [CNT_W-1:0]   rd_ptr;
  logic               rd_valid;
  logic [DRAIN_W-1:0] drain;
  logic [K_W-1:0]     dv_cl;
  logic               dv_axis;
  logic               dv_run;
  logic [IDX_W-1:0]   em_idx;

  logic [COORD_W-1:0] mem_x [MAX_POINTS];
  logic [COORD_W-1:0] mem_y [MAX_POINTS];
  logic [COORD_W-1:0] rd_x, rd_y;

  logic in_xfer, out_xfer, pt_wr, em_final, dv_skip;
  logic [K_W-1:0] k_sat;

  cell_ctrl_t ctrl;
  link_t      links [NCELL+1];
  cell_stat_t stats [NCELL];
  acc_t       acc;
  cell_stat_t dv_stat, em_stat;

  logic               dv_start, dv_done;
  logic [COORD_W-1:0] dv_q;

  assign in_xfer  = sample.valid && sample.ready;
  assign out_xfer = result.valid && result.ready;
  assign pt_wr    = in_xfer && !sample.kind && loaded < CNT_W'(MAX_POINTS);
  assign em_final = {1'b0, em_idx} == k - K_W'(1);

  always_comb begin
    priority if (cluster_count == '0) k_sat = K_W'(1);
    else if (cluster_count > K_W'(NCELL)) k_sat = K_W'(NCELL);
    else k_sat = cluster_count;
  end

  assign dv_stat = stats[dv_cl[IDX_W-1:0]];
  assign em_stat = stats[em_idx];
  assign dv_skip = dv_stat.cnt == '0;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count   <= DEFAULT_CLUSTERS;
      iteration_count <= DEFAULT_ITERATIONS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_CLUSTER_COUNT:   cluster_count   <= cfg_data[K_W-1:0];
        REG_ITERATION_COUNT: iteration_count <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // point memory
  always_ff @(posedge clk) begin
    if (pt_wr) begin
      mem_x[loaded[PTR_W-1:0]] <= sample.coord_x;
      mem_y[loaded[PTR_W-1:0]] <= sample.coord_y;
    end
    rd_x <= mem_x[rd_ptr[PTR_W-1:0]];
    rd_y <= mem_y[rd_ptr[PTR_W-1:0]];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:   if (in_xfer && sample.last) state_next = S_CLEAR;
      S_CLEAR:  state_next = (iters_left == '0) ? S_EMIT : S_STREAM;
      S_STREAM: if (rd_ptr == loaded) state_next = S_DRAIN;
      S_DRAIN:  if (drain == DRAIN_W'(DRAIN_LEN)) state_next = S_DIV;
      S_DIV:    if (dv_cl == k) state_next = S_CLEAR;
      S_EMIT:   if (out_xfer && em_final) state_next = S_LOAD;
      default:  state_next = S_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl          = '0;
    ctrl.k        = k;
    // counts clear at the start of a run and of every pass, and stay after the last pass
    ctrl.clr      = (state == S_CLEAR && iters_left != '0)
                    || (state == S_LOAD && sample.valid && sample.last);
    dv_start      = 1'b0;
    sample.ready  = 1'b0;
    result.valid  = 1'b0;
    unique case (state)
      S_LOAD: begin
        sample.ready  = 1'b1;
        ctrl.wr_x     = sample.valid && sample.kind;
        ctrl.wr_y     = sample.valid && sample.kind;
        ctrl.wr_idx   = sample.centroid_slot;
        ctrl.wr_x_val = sample.coord_x;
        ctrl.wr_y_val = sample.coord_y;
      end
      S_DIV: begin
        dv_start      = dv_cl != k && !dv_skip && !dv_run;
        ctrl.wr_x     = dv_done && !dv_axis;
        ctrl.wr_y     = dv_done && dv_axis;
        ctrl.wr_idx   = dv_cl[IDX_W-1:0];
        ctrl.wr_x_val = dv_q;
        ctrl.wr_y_val = dv_q;
      end
      S_EMIT:  result.valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      loaded     <= '0;
      drop       <= 1'b0;
      k          <= K_W'(1);
      iters_left <= '0;
      rd_ptr     <= '0;
      rd_valid   <= 1'b0;
      drain      <= '0;
      dv_cl      <= '0;
      dv_axis    <= 1'b0;
      dv_run     <= 1'b0;
      em_idx     <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= state == S_STREAM && rd_ptr != loaded;
      unique case (state)
        S_LOAD: begin
          if (pt_wr) loaded <= loaded + CNT_W'(1);
          if (in_xfer && !sample.kind && loaded == CNT_W'(MAX_POINTS)) drop <= 1'b1;
          if (in_xfer && sample.last) begin
            k          <= k_sat;
            iters_left <= iteration_count;
          end
          em_idx <= '0;
        end
        S_CLEAR: begin
          rd_ptr <= '0;
          drain  <= '0;
        end
        S_STREAM: begin
          if (rd_ptr != loaded) rd_ptr <= rd_ptr + CNT_W'(1);
          dv_cl   <= '0;
          dv_axis <= 1'b0;
          dv_run  <= 1'b0;
        end
        S_DRAIN: drain <= drain + DRAIN_W'(1);
        S_DIV: begin
          if (dv_cl == k) begin
            iters_left <= iters_left - ITER_W'(1);
          end else if (!dv_run) begin
            if (dv_skip) dv_cl <= dv_cl + K_W'(1);
            else dv_run <= 1'b1;
          end else if (dv_done) begin
            dv_run  <= 1'b0;
            dv_axis <= !dv_axis;
            if (dv_axis) dv_cl <= dv_cl + K_W'(1);
          end
        end
        S_EMIT: begin
          if (out_xfer) begin
            em_idx <= em_idx + IDX_W'(1);
            if (em_final) begin
              loaded <= '0;
              drop   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // cell chain
  always_comb begin
    links[0]       = '0;
    links[0].valid = rd_valid;
    links[0].px    = rd_x;
    links[0].py    = rd_y;
  end

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    kmc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (IDX_W'(c)),
      .ctrl    (ctrl),
      .li      (links[c]),
      .lo      (links[c+1]),
      .acc     (acc),
      .stat    (stats[c])
    );
  end

  assign acc.valid = links[NCELL].valid;
  assign acc.idx   = links[NCELL].idx;
  assign acc.px    = links[NCELL].px;
  assign acc.py    = links[NCELL].py;

  kmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_axis ? dv_stat.sy : dv_stat.sx),
    .divisor  (dv_stat.cnt),
    .done     (dv_done),
    .quotient (dv_q)
  );

  assign result.cluster_index = em_idx;
  assign result.center_x      = em_stat.cx;
  assign result.center_y      = em_stat.cy;
  assign result.member_count  = em_stat.cnt;
  assign result.overflowed    = drop;
  assign result.final_res     = em_final;

  a_one_side: assert property (@(posedge clk) disable iff (rst)
                               !(sample.ready && result.valid))
    else $error("input open while results pending");
  a_capacity: assert property (@(posedge clk) disable iff (rst)
                               loaded <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");
  a_emit_idx: assert property (@(posedge clk) disable iff (rst)
                               !(result.valid && {1'b0, em_idx} >= k))
    else $error("result index beyond cluster count");
  a_acc_idx: assert property (@(posedge clk) disable iff (rst)
                              !(acc.valid && {1'b0, acc.idx} >= k))
    else $error("point assigned to unused cluster");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
                                !(dv_done && state != S_DIV))
    else $error("divider finished outside update");

endmodule
